// File: rtl/yuvup_pkg.sv
// ----------------------------------------------------------------------------
// yuvup_pkg
// Shared sizes, register indexes and item codes of the 4:2:0 to 4:4:4
// chroma upsampler.
// ----------------------------------------------------------------------------
package yuvup_pkg;

	// largest frame the line stores are sized for
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// counter and address widths that follow from the frame bounds
	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_HEIGHT);
	localparam int WS_W       = $clog2(MAX_WIDTH + 1);
	localparam int HS_W       = $clog2(MAX_HEIGHT + 1);
	localparam int CA_W       = X_W - 1;
	localparam int LINE_DEPTH = 2 ** CA_W;

	// configuration port
	localparam int CFG_W  = 13;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_FILTER_MODE  = 2'd2;

	localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
	localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

	// item kinds and filter modes
	localparam logic OP_CHROMA   = 1'b0;
	localparam logic OP_LUMA     = 1'b1;
	localparam logic MODE_NEAR   = 1'b0;
	localparam logic MODE_BILIN  = 1'b1;

	// one chroma pair as held in a line store entry: cb high, cr low
	typedef logic [15:0] chroma_pair_t;

endpackage

// File: rtl/yuv420_chroma_upsampler_core.sv
// ----------------------------------------------------------------------------
// yuv420_chroma_upsampler_core
// 4:2:0 to 4:4:4 chroma upsampler with two ping-pong chroma line stores,
// nearest or bilinear filtering, one output pixel per luma request.
// ----------------------------------------------------------------------------
// The block takes one request per clock, chroma pair or luma sample, and
// keeps doing so while a finished pixel waits in the output register; input
// stall rises only when both the line-store read stage and the output stage
// are full and the output is stalled. A luma request passes the registered
// line-store read (each store reads columns k and k+1 through two read ports)
// and the weighted blend into the output register. Chroma requests write the
// store of their row parity at acceptance and give no pixel, nor does a
// request of the wrong kind. The user must write frame size and filter mode
// between frames only; the block itself does not enforce it.
module yuv420_chroma_upsampler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// input requests
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [7:0]                    luma_sample,
	input  logic [7:0]                    cb_sample,
	input  logic [7:0]                    cr_sample,
	// output pixels
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_luma,
	output logic [7:0]                    out_cb,
	output logic [7:0]                    out_cr,
	output logic                          end_of_line,
	output logic                          end_of_frame,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [yuvup_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [yuvup_pkg::CFG_W-1:0]   cfg_data
);
	import yuvup_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic             filter_mode_q;

	// frame position state
	logic [X_W-1:0]   pix_col_q;
	logic [Y_W-1:0]   pix_row_q;
	logic [CA_W-1:0]  chroma_col_q;
	logic             chroma_par_q;
	logic             expect_chroma_q;

	// effective sizes
	logic [WS_W-1:0]  w_eff;
	logic [HS_W-1:0]  h_eff;
	logic [31:0]      w_tmp;
	logic [31:0]      h_tmp;
	logic [CA_W-1:0]  cw_m1;
	logic [Y_W-2:0]   ch_m1;

	// request decode
	logic             in_acc;
	logic             chroma_acc;
	logic             luma_acc;
	logic             en1;
	logic             en2;

	// stage 0 address and weight logic
	logic [CA_W-1:0]  k_s0;
	logic [CA_W-1:0]  k2_s0;
	logic [CA_W:0]    k2_full;
	logic [Y_W-2:0]   rh;
	logic [Y_W-1:0]   top_s0;
	logic [Y_W-1:0]   bot_s0;
	logic [2:0]       wt_s0;
	logic [1:0]       wb_s0;
	logic             top_par_s0;
	logic             bot_par_s0;
	logic             eol_s0;
	logic             eof_s0;
	logic             chroma_last;

	// line stores
	chroma_pair_t     line_even [LINE_DEPTH];
	chroma_pair_t     line_odd  [LINE_DEPTH];

	// stage 1: read data and control
	chroma_pair_t     rd_ea_s1;
	chroma_pair_t     rd_eb_s1;
	chroma_pair_t     rd_oa_s1;
	chroma_pair_t     rd_ob_s1;
	logic             v_s1;
	logic             top_par_s1;
	logic             bot_par_s1;
	logic [2:0]       wt_s1;
	logic [1:0]       wb_s1;
	logic             odd_s1;
	logic [7:0]       luma_s1;
	logic             eol_s1;
	logic             eof_s1;

	// stage 1 blend
	chroma_pair_t     t0;
	chroma_pair_t     t1;
	chroma_pair_t     b0;
	chroma_pair_t     b1;
	logic [7:0]       cb_blend;
	logic [7:0]       cr_blend;

	// stage 2: output register
	logic             v_s2;
	logic [7:0]       luma_s2;
	logic [7:0]       cb_s2;
	logic [7:0]       cr_s2;
	logic             eol_s2;
	logic             eof_s2;

	// rounded blend with weights summing to four
	function automatic logic [7:0] blend(input logic [7:0] a0, input logic [7:0] a1,
			input logic [7:0] c0, input logic [7:0] c1, input logic [2:0] wt,
			input logic [1:0] wb, input logic odd);
		logic [10:0] se;
		logic [8:0]  ts;
		logic [8:0]  bs;
		logic [12:0] so;
		se = 11'(wt) * 11'(a0) + 11'(wb) * 11'(c0) + 11'd2;
		ts = 9'(a0) + 9'(a1);
		bs = 9'(c0) + 9'(c1);
		so = 13'({wt, 1'b0}) * 13'(ts) + 13'({wb, 1'b0}) * 13'(bs) + 13'd8;
		blend = odd ? so[11:4] : se[9:2];
	endfunction

	// register writes, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			filter_mode_q  <= MODE_BILIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				CFG_FILTER_MODE:  filter_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sizes in use: even, at least two, at most the store bound
	always_comb begin
		w_tmp = 32'({frame_width_q[CFG_W-1:1], 1'b0});
		h_tmp = 32'({frame_height_q[CFG_W-1:1], 1'b0});
		if (w_tmp < 32'd2) w_tmp = 32'd2;
		if (w_tmp > 32'(MAX_WIDTH & ~1)) w_tmp = 32'(MAX_WIDTH & ~1);
		if (h_tmp < 32'd2) h_tmp = 32'd2;
		if (h_tmp > 32'(MAX_HEIGHT & ~1)) h_tmp = 32'(MAX_HEIGHT & ~1);
		w_eff = WS_W'(w_tmp);
		h_eff = HS_W'(h_tmp);
		cw_m1 = CA_W'((w_eff >> 1) - WS_W'(1));
		ch_m1 = (Y_W-1)'((h_eff >> 1) - HS_W'(1));
	end

	// handshake and pipeline enables
	assign en2      = !v_s2 || !out_stall;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign in_acc     = in_valid && !in_stall;
	assign chroma_acc = in_acc && (op == OP_CHROMA) && expect_chroma_q;
	assign luma_acc   = in_acc && (op == OP_LUMA) && !expect_chroma_q;

	// columns to read, clamped to the last chroma column
	always_comb begin
		k_s0 = pix_col_q[X_W-1:1];
		if (k_s0 > cw_m1) k_s0 = cw_m1;
		k2_full = {1'b0, k_s0} + (CA_W+1)'(1);
		k2_s0 = (k2_full > {1'b0, cw_m1}) ? cw_m1 : k2_full[CA_W-1:0];
	end

	// chroma rows and weights for this luma row
	always_comb begin
		rh = pix_row_q[Y_W-1:1];
		if (filter_mode_q == MODE_NEAR) begin
			top_s0 = Y_W'(rh);
			bot_s0 = Y_W'(rh);
			wt_s0  = 3'd4;
			wb_s0  = 2'd0;
		end else if (pix_row_q == '0) begin
			// first row has zero bottom weight, so keep both reads on row zero
			top_s0 = '0;
			bot_s0 = '0;
			wt_s0  = 3'd4;
			wb_s0  = 2'd0;
		end else if (pix_row_q[0]) begin
			top_s0 = Y_W'(rh);
			bot_s0 = Y_W'(rh) + Y_W'(1);
			wt_s0  = 3'd3;
			wb_s0  = 2'd1;
		end else begin
			top_s0 = Y_W'(rh) - Y_W'(1);
			bot_s0 = Y_W'(rh);
			wt_s0  = 3'd1;
			wb_s0  = 2'd3;
		end
		top_par_s0 = (top_s0 > Y_W'(ch_m1)) ? ch_m1[0] : top_s0[0];
		bot_par_s0 = (bot_s0 > Y_W'(ch_m1)) ? ch_m1[0] : bot_s0[0];
	end

	// row and frame ends
	assign eol_s0 = (WS_W'(pix_col_q) + WS_W'(1)) >= w_eff;
	assign eof_s0 = eol_s0 && ((HS_W'(pix_row_q) + HS_W'(1)) >= h_eff);
	assign chroma_last = (WS_W'(chroma_col_q) + WS_W'(1)) >= (w_eff >> 1);

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_col_q       <= '0;
			pix_row_q       <= '0;
			chroma_col_q    <= '0;
			chroma_par_q    <= 1'b0;
			expect_chroma_q <= 1'b1;
		end else if (chroma_acc) begin
			if (chroma_last) begin
				chroma_col_q    <= '0;
				chroma_par_q    <= !chroma_par_q;
				expect_chroma_q <= 1'b0;
			end else begin
				chroma_col_q <= chroma_col_q + CA_W'(1);
			end
		end else if (luma_acc) begin
			if (eof_s0) begin
				pix_col_q       <= '0;
				pix_row_q       <= '0;
				chroma_col_q    <= '0;
				chroma_par_q    <= 1'b0;
				expect_chroma_q <= 1'b1;
			end else if (eol_s0) begin
				pix_col_q <= '0;
				pix_row_q <= pix_row_q + Y_W'(1);
				if (!pix_row_q[0] && ((HS_W'(pix_row_q) + HS_W'(2)) < h_eff)) begin
					expect_chroma_q <= 1'b1;
				end
			end else begin
				pix_col_q <= pix_col_q + X_W'(1);
			end
		end
	end

	// even-row line store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (chroma_acc && !chroma_par_q) begin
			line_even[chroma_col_q] <= {cb_sample, cr_sample};
		end
		if (en1) begin
			rd_ea_s1 <= line_even[k_s0];
			rd_eb_s1 <= line_even[k2_s0];
		end
	end

	// odd-row line store
	always_ff @(posedge clk) begin
		if (chroma_acc && chroma_par_q) begin
			line_odd[chroma_col_q] <= {cb_sample, cr_sample};
		end
		if (en1) begin
			rd_oa_s1 <= line_odd[k_s0];
			rd_ob_s1 <= line_odd[k2_s0];
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= luma_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			top_par_s1 <= top_par_s0;
			bot_par_s1 <= bot_par_s0;
			wt_s1      <= wt_s0;
			wb_s1      <= wb_s0;
			odd_s1     <= pix_col_q[0] && (filter_mode_q == MODE_BILIN);
			luma_s1    <= luma_sample;
			eol_s1     <= eol_s0;
			eof_s1     <= eof_s0;
		end
	end

	// pick top and bottom rows by parity, then blend
	always_comb begin
		t0 = top_par_s1 ? rd_oa_s1 : rd_ea_s1;
		t1 = top_par_s1 ? rd_ob_s1 : rd_eb_s1;
		b0 = bot_par_s1 ? rd_oa_s1 : rd_ea_s1;
		b1 = bot_par_s1 ? rd_ob_s1 : rd_eb_s1;
		cb_blend = blend(t0[15:8], t1[15:8], b0[15:8], b1[15:8], wt_s1, wb_s1, odd_s1);
		cr_blend = blend(t0[7:0], t1[7:0], b0[7:0], b1[7:0], wt_s1, wb_s1, odd_s1);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			luma_s2 <= luma_s1;
			cb_s2   <= cb_blend;
			cr_s2   <= cr_blend;
			eol_s2  <= eol_s1;
			eof_s2  <= eof_s1;
		end
	end

	assign out_valid    = v_s2;
	assign out_luma     = luma_s2;
	assign out_cb       = cb_s2;
	assign out_cr       = cr_s2;
	assign end_of_line  = eol_s2;
	assign end_of_frame = eof_s2;

	// input stalls only when both stages hold pixels and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_stall))
		else $error("input stall without a full pipeline");

	// an accepted luma request always reaches the read stage
	a_luma_enters: assert property (@(posedge clk) disable iff (!arst_n)
		luma_acc |=> v_s1)
		else $error("luma request lost");

	// end of frame rewinds the position and waits for chroma
	a_frame_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(luma_acc && eof_s0) |=> (expect_chroma_q && (pix_col_q == '0) &&
			(pix_row_q == '0) && (chroma_col_q == '0)))
		else $error("frame counters not rewound");

endmodule
